/* sv/wkb_pkg.sv */
// package for the wkb geometry stream parser: phases, result codes, widths
package wkb_pkg;

  localparam int COUNT_BITS_DEFAULT = 32;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_TYPE   = 4'd1,
    PH_PARTS  = 4'd2,
    PH_MORDER = 4'd3,
    PH_MTYPE  = 4'd4,
    PH_RINGS  = 4'd5,
    PH_POINTS = 4'd6,
    PH_X      = 4'd7,
    PH_Y      = 4'd8,
    PH_DONE   = 4'd9
  } phase_t;

  localparam logic [1:0] KIND_POINT = 2'd0;
  localparam logic [1:0] KIND_EMPTY = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_TYPE      = 2'd1;
  localparam logic [1:0] ERR_MISMATCH  = 2'd2;
  localparam logic [1:0] ERR_TRUNCATED = 2'd3;

  localparam logic [2:0] GT_POINT   = 3'd1;
  localparam logic [2:0] GT_LINE    = 3'd2;
  localparam logic [2:0] GT_POLYGON = 3'd3;
  localparam logic [2:0] GT_MPOINT  = 3'd4;
  localparam logic [2:0] GT_MLINE   = 3'd5;
  localparam logic [2:0] GT_MPOLY   = 3'd6;

  // header of a geometry: byte-order byte plus type word
  localparam int HEADER_BYTES = 5;

endpackage

/* sv/wkb_geometry_stream_parser.sv */
// top level of the wkb geometry stream parser
//
//  channel | handshake             | payload
//  --------+-----------------------+---------------------------------------------
//  input   | valid_in, stall_in    | data_byte, first_byte, end_of_buffer
//  output  | valid_out, stall_out  | result_kind, x/y bits, kind, numbers, marks
//
// one byte per cycle while stall_in is low; each accepted transaction is parsed in the
// cycle it is taken, with its result (if any) landing in the output register
// reset returns the parser to idle, waiting for a byte marked first_byte
// stall_in is raised only while a result waits and the downstream stalls;
// a byte is taken in the same cycle the waiting result leaves
module wkb_geometry_stream_parser import wkb_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid_in,
  output logic        stall_in,
  input  logic [7:0]  data_byte,
  input  logic        first_byte,
  input  logic        end_of_buffer,
  output logic        valid_out,
  input  logic        stall_out,
  output logic [1:0]  result_kind,
  output logic [63:0] x_bits,
  output logic [63:0] y_bits,
  output logic [2:0]  geometry_kind,
  output logic [31:0] part_number,
  output logic [31:0] ring_number,
  output logic [31:0] point_number,
  output logic        ring_done,
  output logic        geometry_done,
  output logic [1:0]  error_code
);

  localparam logic [31:0] CMAX = 32'((64'd1 << COUNT_BITS) - 64'd1);

  phase_t      phase, phase_next;
  logic        top_little, mem_little, top_little_next, mem_little_next;
  logic [2:0]  top_type, top_type_next;
  logic [COUNT_BITS-1:0] parts_total, parts_total_next, part_index, part_index_next;
  logic [COUNT_BITS-1:0] rings_total, rings_total_next, ring_index, ring_index_next;
  logic [COUNT_BITS-1:0] points_total, points_total_next, point_index, point_index_next;
  logic [63:0] held_x, held_x_next;

  logic        take;
  logic        g_clear, g_step, g_full, g_little, g_long;
  logic [63:0] g_word;
  logic [31:0] w;
  logic [COUNT_BITS-1:0] wsat;

  logic        emit;
  logic [1:0]  kind, err;
  logic [COUNT_BITS-1:0] pn, rn, qn;
  logic        rdone, gdone, is_point;

  assign stall_in = valid_out && stall_out;
  assign take     = valid_in && !stall_in;

  wkb_gather u_gather (
    .clk        (clk),
    .clear      (g_clear),
    .step       (g_step),
    .data_byte  (data_byte),
    .little     (g_little),
    .long_field (g_long),
    .full       (g_full),
    .word       (g_word)
  );

  // assembler starts afresh on reset, a new buffer and each member order byte
  assign g_clear = rst || (take && (first_byte || phase == PH_MORDER));
  assign g_step  = take && !first_byte && phase != PH_IDLE && phase != PH_DONE
                   && phase != PH_MORDER;
  assign g_little = (phase == PH_TYPE || phase == PH_PARTS) ? top_little : mem_little;
  assign g_long   = (phase == PH_X || phase == PH_Y);
  assign w        = g_word[31:0];
  assign wsat     = (w > CMAX) ? CMAX[COUNT_BITS-1:0] : w[COUNT_BITS-1:0];

  always_comb begin
    logic mp, poly, single, ended, pi_n, ri_n;
    logic [COUNT_BITS-1:0] pinc, rinc, qinc;
    phase_next = phase;
    top_little_next = top_little;
    mem_little_next = mem_little;
    top_type_next = top_type;
    parts_total_next = parts_total;
    part_index_next = part_index;
    rings_total_next = rings_total;
    ring_index_next = ring_index;
    points_total_next = points_total;
    point_index_next = point_index;
    held_x_next = held_x;
    emit = 1'b0;
    kind = KIND_EMPTY;
    err = ERR_NONE;
    pn = '0; rn = '0; qn = '0;
    rdone = 1'b0; gdone = 1'b0; is_point = 1'b0;
    mp = top_type >= GT_MPOINT;
    poly = top_type == GT_POLYGON || top_type == GT_MPOLY;
    single = top_type == GT_POINT || top_type == GT_MPOINT;
    pinc = part_index + 1'b1;
    rinc = ring_index + 1'b1;
    qinc = point_index + 1'b1;
    pi_n = pinc < parts_total;
    ri_n = rinc < rings_total;
    ended = 1'b0;
    if (take) begin
      if (first_byte) begin
        top_little_next = data_byte[0];
        mem_little_next = data_byte[0];
        top_type_next = '0;
        parts_total_next = '0; part_index_next = '0;
        rings_total_next = '0; ring_index_next = '0;
        points_total_next = '0; point_index_next = '0;
        held_x_next = '0;
        phase_next = PH_TYPE;
      end else if (phase == PH_MORDER) begin
        mem_little_next = data_byte[0];
        phase_next = PH_MTYPE;
      end else if (phase != PH_IDLE && phase != PH_DONE && g_full) begin
        case (phase)
          PH_TYPE: begin
            if (w >= 32'd1 && w <= 32'd6) begin
              top_type_next = w[2:0];
              if (w <= 32'd3) begin
                ring_index_next = '0; point_index_next = '0;
                phase_next = (w == 32'd1) ? PH_X : (w == 32'd2) ? PH_POINTS : PH_RINGS;
              end else begin
                phase_next = PH_PARTS;
              end
            end else begin
              top_type_next = '0;
              err = ERR_TYPE;
            end
          end
          PH_PARTS: begin
            parts_total_next = wsat;
            part_index_next = '0; ring_index_next = '0; point_index_next = '0;
            if (wsat == '0) begin
              phase_next = PH_DONE; emit = 1'b1;
            end else phase_next = PH_MORDER;
          end
          PH_MTYPE: begin
            if (w != {29'd0, top_type - 3'd3}) err = ERR_MISMATCH;
            else begin
              ring_index_next = '0; point_index_next = '0;
              phase_next = (w == 32'd1) ? PH_X : (w == 32'd2) ? PH_POINTS : PH_RINGS;
            end
          end
          PH_RINGS: begin
            rings_total_next = wsat;
            ring_index_next = '0;
            if (wsat == '0) begin
              // zero rings: polygon/member is empty, close the part
              if (mp) begin
                part_index_next = pinc;
                phase_next = pi_n ? PH_MORDER : PH_DONE;
                emit = !pi_n;
              end else begin
                phase_next = PH_DONE; emit = 1'b1;
              end
            end else phase_next = PH_POINTS;
          end
          PH_POINTS: begin
            points_total_next = wsat;
            point_index_next = '0;
            if (wsat == '0) begin
              if (poly && ri_n) begin
                ring_index_next = rinc; phase_next = PH_POINTS;
              end else begin
                if (poly) ring_index_next = rinc;
                if (mp) begin
                  part_index_next = pinc;
                  phase_next = pi_n ? PH_MORDER : PH_DONE;
                  emit = !pi_n;
                end else begin
                  phase_next = PH_DONE; emit = 1'b1;
                end
              end
            end else phase_next = PH_X;
          end
          PH_X: begin
            held_x_next = g_word;
            phase_next = PH_Y;
          end
          default: begin
            emit = 1'b1; kind = KIND_POINT; is_point = 1'b1;
            pn = mp ? part_index : '0;
            rn = poly ? ring_index : '0;
            qn = single ? '0 : point_index;
            rdone = single ? 1'b1 : (qinc >= points_total);
            if (!single && qinc < points_total) begin
              point_index_next = qinc; phase_next = PH_X;
            end else begin
              if (!single) point_index_next = qinc;
              if (!single && poly && ri_n) begin
                ring_index_next = rinc; phase_next = PH_POINTS;
              end else begin
                if (!single && poly) ring_index_next = rinc;
                if (mp) begin
                  part_index_next = pinc;
                  phase_next = pi_n ? PH_MORDER : PH_DONE;
                  ended = !pi_n;
                end else begin
                  phase_next = PH_DONE; ended = 1'b1;
                end
              end
            end
            gdone = ended;
          end
        endcase
      end
      // truncation only counts for bytes that are actually parsed
      if ((first_byte || (phase != PH_IDLE && phase != PH_DONE)) && err == ERR_NONE
          && end_of_buffer && phase_next != PH_DONE)
        err = ERR_TRUNCATED;
      if (err != ERR_NONE) begin
        phase_next = PH_DONE; emit = 1'b1; kind = KIND_ERROR; is_point = 1'b0;
      end
    end
    if (!is_point) begin
      pn = '0; rn = '0; qn = '0; rdone = 1'b0; gdone = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      top_little <= 1'b0; mem_little <= 1'b0; top_type <= '0;
      parts_total <= '0; part_index <= '0; rings_total <= '0;
      ring_index <= '0; points_total <= '0; point_index <= '0;
      held_x <= '0;
      valid_out <= 1'b0;
    end else begin
      phase <= phase_next;
      top_little <= top_little_next; mem_little <= mem_little_next;
      top_type <= top_type_next;
      parts_total <= parts_total_next; part_index <= part_index_next;
      rings_total <= rings_total_next; ring_index <= ring_index_next;
      points_total <= points_total_next; point_index <= point_index_next;
      held_x <= held_x_next;
      if (take) valid_out <= emit;
      else if (!stall_out) valid_out <= 1'b0;
    end
  end

  // result register, loaded only when a new transaction produces a result
  always_ff @(posedge clk) begin
    if (take && emit) begin
      result_kind   <= kind;
      x_bits        <= is_point ? held_x : 64'd0;
      y_bits        <= is_point ? g_word : 64'd0;
      geometry_kind <= top_type_next;
      part_number   <= 32'(pn);
      ring_number   <= 32'(rn);
      point_number  <= 32'(qn);
      ring_done     <= rdone;
      geometry_done <= gdone;
      error_code    <= err;
    end
  end

  a_err_kind: assert property (@(posedge clk) disable iff (rst)
    valid_out |-> ((result_kind == KIND_ERROR) == (error_code != ERR_NONE)))
    else $error("error code and kind disagree");
  a_nonpoint_done: assert property (@(posedge clk) disable iff (rst)
    (valid_out && result_kind != KIND_POINT) |-> geometry_done)
    else $error("non-point result not final");
  a_done_phase: assert property (@(posedge clk) disable iff (rst)
    ($past(take) && valid_out && geometry_done) |-> phase == PH_DONE)
    else $error("geometry ended but parser still active");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (valid_out && stall_out) |=> valid_out)
    else $error("stalled result dropped");

endmodule

/* sv/wkb_gather.sv */
// byte assembler: collects a 4 or 8 byte field in either byte order
module wkb_gather import wkb_pkg::*; (
  input  logic        clk,
  input  logic        clear,
  input  logic        step,
  input  logic [7:0]  data_byte,
  input  logic        little,
  input  logic        long_field,
  output logic        full,
  output logic [63:0] word
);

  logic [2:0]  count;
  logic [63:0] acc;
  logic [63:0] acc_next;

  always_comb begin
    if (little) begin
      acc_next = acc | ({56'd0, data_byte} << {count, 3'b000});
    end else begin
      acc_next = {acc[55:0], data_byte};
    end
    full = long_field ? (count == 3'd7) : (count >= 3'd3);
    word = acc_next;
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      count <= '0;
      acc   <= '0;
    end else if (step) begin
      if (full) begin
        count <= '0;
        acc   <= '0;
      end else begin
        count <= count + 3'd1;
        acc   <= acc_next;
      end
    end
  end

endmodule

/* bench/tb_wkb_geometry_stream_parser.sv */
// testbench for the wkb geometry stream parser: directed rows, then random geometries
`timescale 1ns / 1ps

module tb_wkb_geometry_stream_parser;
  import wkb_pkg::*;

  // a result as the parser presents it on its output port
  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] x;
    logic [63:0] y;
    logic [2:0]  gkind;
    logic [31:0] part;
    logic [31:0] ring;
    logic [31:0] point;
    logic        rdone;
    logic        gdone;
    logic [1:0]  err;
  } geom_result_t;

  // one directed row; where fixed is set the result is typed in here
  typedef struct packed {
    logic [7:0] b;
    logic       fb;
    logic       eob;
    logic       fixed;
    logic [1:0] kind;
    logic [2:0] gkind;
    logic [1:0] err;
  } dir_row_t;

  localparam int RANDOM_BYTES = 1550;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DIR_ROWS     = 29;

  logic        clk;
  logic        rst;
  logic        valid_in;
  logic        stall_in;
  logic [7:0]  data_byte;
  logic        first_byte;
  logic        end_of_buffer;
  logic        valid_out;
  logic        stall_out;
  logic [1:0]  result_kind;
  logic [63:0] x_bits;
  logic [63:0] y_bits;
  logic [2:0]  geometry_kind;
  logic [31:0] part_number;
  logic [31:0] ring_number;
  logic [31:0] point_number;
  logic        ring_done;
  logic        geometry_done;
  logic [1:0]  error_code;

  wkb_geometry_stream_parser dut (
    .clk(clk), .rst(rst),
    .valid_in(valid_in), .stall_in(stall_in),
    .data_byte(data_byte), .first_byte(first_byte), .end_of_buffer(end_of_buffer),
    .valid_out(valid_out), .stall_out(stall_out),
    .result_kind(result_kind), .x_bits(x_bits), .y_bits(y_bits),
    .geometry_kind(geometry_kind), .part_number(part_number),
    .ring_number(ring_number), .point_number(point_number),
    .ring_done(ring_done), .geometry_done(geometry_done), .error_code(error_code)
  );

  geom_result_t pending_results[$];
  int           mismatch_count = 0;
  int           idle_cycles = 0;
  int           quiet_left = 0;
  logic [7:0]   geom_bytes[$];

  // directed rows: unsupported type, header cut at its first byte, polygon with no
  // rings, and a multipolygon whose member claims to be a linestring
  dir_row_t dir_rows[DIR_ROWS] = '{
    '{8'h01, 1'b1, 1'b0, 1'b0, KIND_POINT, 3'd0, ERR_NONE},
    '{8'h07, 1'b0, 1'b0, 1'b0, KIND_POINT, 3'd0, ERR_NONE},
    '{8'h00, 1'b0, 1'b0, 1'b0, KIND_POINT, 3'd0, ERR_NONE},
    '{8'h00, 1'b0, 1'b0, 1'b0, KIND_POINT, 3'd0, ERR_NONE},
    '{8'h00, 1'b0, 1'b0, 1'b1, KIND_ERROR, 3'd0, ERR_TYPE},
    '{8'h00, 1'b1, 1'b1, 1'b1, KIND_ERROR, 3'd0, ERR_TRUNCATED},
    '{8'hff, 1'b1, 1'b0, 1'b0, KIND_POINT, 3'd0, ERR_NONE},
    '{8'h03, 1'b0, 1'b0, 1'b0, KIND_POINT, 3'd0, ERR_NONE},
    '{8'h00, 1'b0, 1'b0, 1'b0, KIND_POINT, 3'd0, ERR_NONE},
    '{8'h00, 1'b0, 1'b0, 1'b0, KIND_POINT, 3'd0, ERR_NONE},
    '{8'h00, 1'b0, 1'b0, 1'b0, KIND_POINT, 3'd0, ERR_NONE},
    '{8'h00, 1'b0, 1'b0, 1'b0, KIND_POINT, 3'd0, ERR_NONE},
    '{8'h00, 1'b0, 1'b0, 1'b0, KIND_POINT, 3'd0, ERR_NONE},
    '{8'h00, 1'b0, 1'b0, 1'b0, KIND_POINT, 3'd0, ERR_NONE},
    '{8'h00, 1'b0, 1'b1, 1'b1, KIND_EMPTY, GT_POLYGON, ERR_NONE},
    '{8'hfe, 1'b1, 1'b0, 1'b0, KIND_POINT, 3'd0, ERR_NONE},
    '{8'h00, 1'b0, 1'b0, 1'b0, KIND_POINT, 3'd0, ERR_NONE},
    '{8'h00, 1'b0, 1'b0, 1'b0, KIND_POINT, 3'd0, ERR_NONE},
    '{8'h00, 1'b0, 1'b0, 1'b0, KIND_POINT, 3'd0, ERR_NONE},
    '{8'h06, 1'b0, 1'b0, 1'b0, KIND_POINT, 3'd0, ERR_NONE},
    '{8'h00, 1'b0, 1'b0, 1'b0, KIND_POINT, 3'd0, ERR_NONE},
    '{8'h00, 1'b0, 1'b0, 1'b0, KIND_POINT, 3'd0, ERR_NONE},
    '{8'h00, 1'b0, 1'b0, 1'b0, KIND_POINT, 3'd0, ERR_NONE},
    '{8'h01, 1'b0, 1'b0, 1'b0, KIND_POINT, 3'd0, ERR_NONE},
    '{8'h00, 1'b0, 1'b0, 1'b0, KIND_POINT, 3'd0, ERR_NONE},
    '{8'h00, 1'b0, 1'b0, 1'b0, KIND_POINT, 3'd0, ERR_NONE},
    '{8'h00, 1'b0, 1'b0, 1'b0, KIND_POINT, 3'd0, ERR_NONE},
    '{8'h00, 1'b0, 1'b0, 1'b0, KIND_POINT, 3'd0, ERR_NONE},
    '{8'h02, 1'b0, 1'b0, 1'b1, KIND_ERROR, GT_MPOLY, ERR_MISMATCH}
  };

  // ---------------------------------------------------------------------------
  // parser state as the bench tracks it
  // ---------------------------------------------------------------------------
  phase_t      pr_phase;
  logic [2:0]  pr_count;
  logic [63:0] pr_word;
  logic [63:0] pr_x;
  logic        pr_top_little;
  logic        pr_member_little;
  logic [2:0]  pr_top;
  logic [31:0] pr_parts, pr_part;
  logic [31:0] pr_rings, pr_ring;
  logic [31:0] pr_points, pr_point;

  function automatic void clear_parser();
    pr_phase = PH_IDLE;
    pr_count = '0;
    pr_word = '0;
    pr_x = '0;
    pr_top_little = 1'b0;
    pr_member_little = 1'b0;
    pr_top = '0;
    pr_parts = '0;
    pr_part = '0;
    pr_rings = '0;
    pr_ring = '0;
    pr_points = '0;
    pr_point = '0;
  endfunction

  // multi geometries move on to the next member, else the geometry is over
  function automatic logic close_part();
    if (pr_top >= GT_MPOINT) begin
      pr_part = pr_part + 1;
      if (pr_part < pr_parts) begin
        pr_phase = PH_MORDER;
        return 1'b0;
      end
    end
    pr_phase = PH_DONE;
    return 1'b1;
  endfunction

  function automatic logic close_ring();
    if (pr_top == GT_POLYGON || pr_top == GT_MPOLY) begin
      pr_ring = pr_ring + 1;
      if (pr_ring < pr_rings) begin
        pr_phase = PH_POINTS;
        return 1'b0;
      end
    end
    return close_part();
  endfunction

  function automatic logic close_point();
    if (pr_top == GT_POINT || pr_top == GT_MPOINT)
      return close_part();
    pr_point = pr_point + 1;
    if (pr_point < pr_points) begin
      pr_phase = PH_X;
      return 1'b0;
    end
    return close_ring();
  endfunction

  function automatic void open_body(logic [2:0] t);
    pr_ring = '0;
    pr_point = '0;
    if (t == GT_POINT)
      pr_phase = PH_X;
    else if (t == GT_LINE)
      pr_phase = PH_POINTS;
    else
      pr_phase = PH_RINGS;
  endfunction

  // parse one byte; has_result tells whether the byte gives a result
  function automatic void parse_wkb_byte(input logic [7:0] b, input logic fb, input logic eob,
                                         output logic has_result,
                                         output geom_result_t res);
    int          kind;
    logic [1:0]  err;
    logic        little;
    logic        full;
    int          len;
    logic [63:0] v;
    logic [31:0] w;
    kind = -1;
    err = ERR_NONE;
    full = 1'b0;
    v = '0;
    res = '0;
    has_result = 1'b0;
    if (fb) begin
      clear_parser();
      pr_top_little = b[0];
      pr_member_little = b[0];
      pr_phase = PH_TYPE;
    end else begin
      if (pr_phase == PH_IDLE || pr_phase >= PH_DONE)
        return;
      if (pr_phase == PH_MORDER) begin
        pr_member_little = b[0];
        pr_count = '0;
        pr_word = '0;
        pr_phase = PH_MTYPE;
      end else begin
        little = (pr_phase == PH_TYPE || pr_phase == PH_PARTS) ? pr_top_little
                                                               : pr_member_little;
        len = (pr_phase == PH_X || pr_phase == PH_Y) ? 8 : 4;
        if (little)
          pr_word = pr_word | (64'(b) << (8 * pr_count));
        else
          pr_word = {pr_word[55:0], b};
        if (int'(pr_count) >= len - 1) begin
          v = pr_word;
          pr_word = '0;
          pr_count = '0;
          full = 1'b1;
        end else begin
          pr_count = pr_count + 1;
        end
        if (full) begin
          w = v[31:0];
          case (pr_phase)
            PH_TYPE: begin
              if (w >= 1 && w <= 6) begin
                pr_top = w[2:0];
                if (w <= 3)
                  open_body(w[2:0]);
                else
                  pr_phase = PH_PARTS;
              end else begin
                pr_top = '0;
                err = ERR_TYPE;
              end
            end
            PH_PARTS: begin
              pr_parts = w;
              pr_part = '0;
              pr_ring = '0;
              pr_point = '0;
              if (pr_parts == 0) begin
                pr_phase = PH_DONE;
                kind = KIND_EMPTY;
              end else begin
                pr_phase = PH_MORDER;
              end
            end
            PH_MTYPE: begin
              if (w != 32'(pr_top) - 32'd3)
                err = ERR_MISMATCH;
              else
                open_body(w[2:0]);
            end
            PH_RINGS: begin
              pr_rings = w;
              pr_ring = '0;
              if (pr_rings == 0) begin
                if (close_part())
                  kind = KIND_EMPTY;
              end else begin
                pr_phase = PH_POINTS;
              end
            end
            PH_POINTS: begin
              pr_points = w;
              pr_point = '0;
              if (pr_points == 0) begin
                if (close_ring())
                  kind = KIND_EMPTY;
              end else begin
                pr_phase = PH_X;
              end
            end
            PH_X: begin
              pr_x = v;
              pr_phase = PH_Y;
            end
            default: begin
              res.x = pr_x;
              res.y = v;
              res.part = (pr_top >= GT_MPOINT) ? pr_part : '0;
              res.ring = (pr_top == GT_POLYGON || pr_top == GT_MPOLY) ? pr_ring : '0;
              if (pr_top == GT_POINT || pr_top == GT_MPOINT) begin
                res.point = '0;
                res.rdone = 1'b1;
              end else begin
                res.point = pr_point;
                res.rdone = (pr_point + 32'd1 >= pr_points);
              end
              res.gdone = close_point();
              kind = KIND_POINT;
            end
          endcase
        end
      end
    end
    // a short buffer outranks a point, but not an error found on this byte
    if (err == ERR_NONE && eob && pr_phase != PH_DONE)
      err = ERR_TRUNCATED;
    if (err != ERR_NONE) begin
      pr_phase = PH_DONE;
      kind = KIND_ERROR;
    end
    if (kind < 0)
      return;
    has_result = 1'b1;
    if (kind != KIND_POINT) begin
      res = '0;
      res.gdone = 1'b1;
    end
    res.kind = kind[1:0];
    res.gkind = pr_top;
    res.err = err;
  endfunction

  // ---------------------------------------------------------------------------
  // clock and reset
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h, wanted %h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // every result leaving the parser is matched against the oldest one pending
  always @(posedge clk) begin
    geom_result_t got, want;
    if (!rst) begin
      if ((valid_in && !stall_in) || (valid_out && !stall_out))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (valid_out && !stall_out) begin
        got = '{result_kind, x_bits, y_bits, geometry_kind, part_number, ring_number,
                point_number, ring_done, geometry_done, error_code};
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing pending, kind", 64'(got.kind), 64'd0);
        end else begin
          want = pending_results.pop_front();
          if (got.kind !== want.kind)   report_mismatch("result_kind", 64'(got.kind), 64'(want.kind));
          if (got.x !== want.x)         report_mismatch("x_bits", got.x, want.x);
          if (got.y !== want.y)         report_mismatch("y_bits", got.y, want.y);
          if (got.gkind !== want.gkind) report_mismatch("geometry_kind", 64'(got.gkind), 64'(want.gkind));
          if (got.part !== want.part)   report_mismatch("part_number", 64'(got.part), 64'(want.part));
          if (got.ring !== want.ring)   report_mismatch("ring_number", 64'(got.ring), 64'(want.ring));
          if (got.point !== want.point) report_mismatch("point_number", 64'(got.point), 64'(want.point));
          if (got.rdone !== want.rdone) report_mismatch("ring_done", 64'(got.rdone), 64'(want.rdone));
          if (got.gdone !== want.gdone) report_mismatch("geometry_done", 64'(got.gdone), 64'(want.gdone));
          if (got.err !== want.err)     report_mismatch("error_code", 64'(got.err), 64'(want.err));
        end
      end
      // nothing moving for too long means the parser has hung
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // downstream stall: short bursts, the odd long one, and quiet stretches
  // ---------------------------------------------------------------------------
  initial begin
    int span;
    logic level;
    stall_out = 1'b0;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 11) == 0) begin
        level = 1'b0;
        span = $urandom_range(60, 200);
      end else begin
        level = ($urandom_range(0, 2) == 0);
        span = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 4);
      end
      stall_out <= level;
      repeat (span) @(posedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  // offer one byte, wait for the transaction, then record what it should give
  task automatic send_byte(input logic [7:0] b, input logic fb, input logic eob,
                           input logic fixed, input geom_result_t fixed_res);
    logic         has;
    geom_result_t res;
    int           gap;
    valid_in <= 1'b1;
    data_byte <= b;
    first_byte <= fb;
    end_of_buffer <= eob;
    @(posedge clk);
    while (stall_in)
      @(posedge clk);
    parse_wkb_byte(b, fb, eob, has, res);
    if (fixed)
      pending_results.insert(pending_results.size(), fixed_res);
    else if (has)
      pending_results.insert(pending_results.size(), res);
    // sender gaps: mostly none, some short, a few long, with gap-free stretches
    gap = 0;
    if (quiet_left > 0) begin
      quiet_left--;
    end else begin
      case ($urandom_range(0, 31))
        0: quiet_left = $urandom_range(50, 200);
        1: gap = $urandom_range(10, 40);
        2, 3, 4, 5, 6, 7, 8, 9, 10, 11: gap = $urandom_range(1, 3);
        default: gap = 0;
      endcase
    end
    if (gap > 0) begin
      valid_in <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic put_word32(input logic [31:0] v, input logic little);
    for (int i = 0; i < 4; i++)
      geom_bytes.insert(geom_bytes.size(), little ? v[8*i +: 8] : v[8*(3-i) +: 8]);
  endtask

  task automatic put_coord(input logic little);
    logic [63:0] v;
    case ($urandom_range(0, 7))
      0: v = '0;
      1: v = '1;
      default: v = {$urandom, $urandom};
    endcase
    for (int i = 0; i < 8; i++)
      geom_bytes.insert(geom_bytes.size(), little ? v[8*i +: 8] : v[8*(7-i) +: 8]);
  endtask

  // mostly short, now and then empty
  function automatic logic [31:0] pick_count();
    return ($urandom_range(0, 7) == 0) ? 32'd0 : 32'($urandom_range(1, 3));
  endfunction

  task automatic put_body(input logic [2:0] t, input logic little);
    logic [31:0] rings, pts;
    if (t == GT_POINT) begin
      put_coord(little);
      put_coord(little);
    end else begin
      rings = (t == GT_POLYGON) ? pick_count() : 32'd1;
      if (t == GT_POLYGON)
        put_word32(rings, little);
      for (int r = 0; r < int'(rings); r++) begin
        pts = pick_count();
        put_word32(pts, little);
        for (int p = 0; p < int'(pts); p++) begin
          put_coord(little);
          put_coord(little);
        end
      end
    end
  endtask

  // build one geometry buffer, mostly well formed, sometimes broken
  task automatic build_geometry();
    logic        little, mlittle;
    logic [31:0] top, parts, mtype;
    geom_bytes.delete();
    little = $urandom_range(0, 1);
    geom_bytes.insert(geom_bytes.size(), {7'($urandom), little});
    case ($urandom_range(0, 24))
      0: top = 32'd0;
      1: top = 32'd7;
      2: top = $urandom;
      default: top = 32'($urandom_range(1, 6));
    endcase
    put_word32(top, little);
    if (top >= 1 && top <= 3) begin
      put_body(top[2:0], little);
    end else if (top >= 4 && top <= 6) begin
      parts = pick_count();
      put_word32(parts, little);
      for (int p = 0; p < int'(parts); p++) begin
        mlittle = $urandom_range(0, 1);
        geom_bytes.insert(geom_bytes.size(), {7'($urandom), mlittle});
        mtype = top - 32'd3;
        if ($urandom_range(0, 15) == 0)
          mtype = ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 7)) : $urandom;
        put_word32(mtype, mlittle);
        if (mtype != top - 32'd3)
          break;
        put_body(mtype[2:0], mlittle);
      end
    end
  endtask

  geom_result_t fixed_res;
  int           sent_random;
  int           cut;
  int           ending;

  initial begin
    valid_in = 1'b0;
    data_byte = '0;
    first_byte = 1'b0;
    end_of_buffer = 1'b0;
    clear_parser();
    @(negedge rst);
    @(posedge clk);

    // directed rows
    for (int i = 0; i < DIR_ROWS; i++) begin
      fixed_res = '0;
      fixed_res.kind = dir_rows[i].kind;
      fixed_res.gkind = dir_rows[i].gkind;
      fixed_res.gdone = 1'b1;
      fixed_res.err = dir_rows[i].err;
      send_byte(dir_rows[i].b, dir_rows[i].fb, dir_rows[i].eob, dir_rows[i].fixed, fixed_res);
    end

    // hold off until the parser has drained everything
    valid_in <= 1'b0;
    while (pending_results.size() != 0)
      @(posedge clk);
    @(posedge clk);

    // random geometries
    fixed_res = '0;
    sent_random = 0;
    while (sent_random < RANDOM_BYTES) begin
      build_geometry();
      cut = geom_bytes.size();
      ending = $urandom_range(0, 9);
      // cut the buffer short, with or without the end mark
      if (ending == 6 || ending == 8)
        cut = $urandom_range(1, geom_bytes.size());
      for (int i = 0; i < cut; i++)
        send_byte(geom_bytes[i], i == 0, (i == cut - 1) && ending != 7 && ending != 8,
                  1'b0, fixed_res);
      sent_random += cut;
      // trailing bytes after the geometry, which the parser ignores
      if (ending == 7 || ending == 9)
        repeat ($urandom_range(1, 3))
          send_byte(8'($urandom), 1'b0, $urandom_range(0, 1), 1'b0, fixed_res);
    end

    valid_in <= 1'b0;
    while (pending_results.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
